// File: rtl/grc_pkg.sv
// shared types and constants for the gamepad report conditioner
// no dependencies; imported by grc_combine, gamepad_report_conditioner_unit and the testbench

package grc_pkg;

    localparam int GRC_NUM_PADS = 4;
    localparam int NUM_LEVELS = 8;
    localparam int LEVEL_W = 8;
    localparam logic [7:0] ANALOG_THRESHOLD_RESET = 8'h30;
    localparam logic [2:0] COMBINED_SOURCE = 3'd4;

    typedef struct packed {
        logic [1:0] pad_index;
        logic present;
        logic [3:0] dpad_bits;
        logic [11:0] other_buttons;
        logic [63:0] analog_levels;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic frame_end;
    } t_in_item;

    typedef struct packed {
        logic [2:0] source;
        logic connected;
        logic [15:0] digital_now;
        logic [15:0] digital_pressed;
        logic [63:0] analog_now;
        logic [7:0] analog_pressed;
        logic signed [15:0] stick_lx;
        logic signed [15:0] stick_ly;
        logic signed [15:0] stick_rx;
        logic signed [15:0] stick_ry;
        logic run_last;
    } t_out_item;

    // stored record of one pad
    typedef struct packed {
        logic [15:0] held_digital;
        logic [15:0] pressed_digital;
        logic [63:0] analog;
        logic [7:0] held_analog;
        logic [7:0] pressed_analog;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] rx;
        logic [15:0] ry;
    } t_pad_rec;

endpackage

// File: rtl/grc_combine.sv
// combined pad builder: or, per-level maximum and wrapped stick sums over all pad records
// depends on grc_pkg

module grc_combine import grc_pkg::*; #(
    parameter int NUM_PADS = GRC_NUM_PADS
) (
    input  t_pad_rec  i_recs [NUM_PADS],
    output t_out_item o_combined
);

    always_comb begin
        logic [15:0] dn;
        logic [15:0] dp;
        logic [7:0] ap;
        logic [63:0] an;
        logic [15:0] slx;
        logic [15:0] sly;
        logic [15:0] srx;
        logic [15:0] sry;
        dn = '0;
        dp = '0;
        ap = '0;
        an = '0;
        slx = '0;
        sly = '0;
        srx = '0;
        sry = '0;
        for (int q = 0; q < NUM_PADS; q++) begin
            dn = dn | i_recs[q].held_digital;
            dp = dp | i_recs[q].pressed_digital;
            ap = ap | i_recs[q].pressed_analog;
            slx = slx + i_recs[q].lx;
            sly = sly + i_recs[q].ly;
            srx = srx + i_recs[q].rx;
            sry = sry + i_recs[q].ry;
            for (int b = 0; b < NUM_LEVELS; b++) begin
                if (i_recs[q].analog[b*LEVEL_W +: LEVEL_W] > an[b*LEVEL_W +: LEVEL_W]) begin
                    an[b*LEVEL_W +: LEVEL_W] = i_recs[q].analog[b*LEVEL_W +: LEVEL_W];
                end
            end
        end
        o_combined.source = COMBINED_SOURCE;
        o_combined.connected = 1'b1;
        o_combined.digital_now = dn;
        o_combined.digital_pressed = dp;
        o_combined.analog_now = an;
        o_combined.analog_pressed = ap;
        o_combined.stick_lx = $signed(slx);
        o_combined.stick_ly = $signed(sly);
        o_combined.stick_rx = $signed(srx);
        o_combined.stick_ry = $signed(sry);
        o_combined.run_last = 1'b1;
    end

endmodule

// File: rtl/gamepad_report_conditioner_unit.sv
// gamepad report conditioner top level: input register, pad records, result register
// depends on grc_pkg and grc_combine
//
// a report goes into the input register, its pad result then into the result register
// throughput: one report per cycle while the result register is free;
// the input register holds a frame_end report for a second pass that emits the combined pad
// reset (synchronous, active low): threshold back to 0x30, all pad records cleared,
// both register stages empty

module gamepad_report_conditioner_unit import grc_pkg::*; #(
    parameter int NUM_PADS = GRC_NUM_PADS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // configuration: analog threshold
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    // raw reports in
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    // conditioned results out
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // configuration register
    logic [7:0] r_thr;

    // input register stage
    logic     r_in_valid;
    t_in_item r_in;
    logic     r_phase;      // high while the combined pad of the held report is due

    // result register
    logic      r_out_valid;
    t_out_item r_out;

    // per-pad records
    t_pad_rec r_rec [NUM_PADS];

    logic      out_free;
    logic      fire;
    logic      last_pass;
    logic      pad_ok;
    logic      pad_fire;
    t_pad_rec  sel_rec;
    t_pad_rec  new_rec;
    t_out_item pad_item;
    t_out_item comb_item;
    t_out_item n_out;

    // result register takes a new result when empty or being drained
    assign out_free  = !r_out_valid || i_out_ready;
    assign fire      = r_in_valid && out_free;
    // the held report leaves after its pad pass, or after the combined pass
    assign last_pass = r_phase || !r_in.frame_end;
    assign o_in_ready = !r_in_valid || (fire && last_pass);

    assign pad_ok   = int'(r_in.pad_index) < NUM_PADS;
    assign pad_fire = fire && !r_phase && pad_ok;

    // record of the addressed pad
    always_comb begin
        sel_rec = '0;
        for (int p = 0; p < NUM_PADS; p++) begin
            if (int'(r_in.pad_index) == p) begin
                sel_rec = r_rec[p];
            end
        end
    end

    // conditioned record for a present pad
    always_comb begin
        logic [63:0] an;
        logic [7:0] hold;
        logic [15:0] dig;
        an = '0;
        hold = '0;
        dig = {r_in.other_buttons, r_in.dpad_bits};
        // levels at or below the threshold read as zero
        for (int b = 0; b < NUM_LEVELS; b++) begin
            if (r_in.analog_levels[b*LEVEL_W +: LEVEL_W] > r_thr) begin
                an[b*LEVEL_W +: LEVEL_W] = r_in.analog_levels[b*LEVEL_W +: LEVEL_W];
                hold[b] = 1'b1;
            end
        end
        new_rec.held_digital = dig;
        // rising edges against the previous held state
        new_rec.pressed_digital = dig & ~sel_rec.held_digital;
        new_rec.analog = an;
        new_rec.held_analog = hold;
        new_rec.pressed_analog = hold & ~sel_rec.held_analog;
        new_rec.lx = r_in.left_x;
        new_rec.ly = r_in.left_y;
        new_rec.rx = r_in.right_x;
        new_rec.ry = r_in.right_y;
    end

    // pad result: zeros for an absent pad or an index beyond the pad count
    always_comb begin
        pad_item = '0;
        pad_item.source = {1'b0, r_in.pad_index};
        pad_item.run_last = !r_in.frame_end;
        if (pad_ok && r_in.present) begin
            pad_item.connected = 1'b1;
            pad_item.digital_now = new_rec.held_digital;
            pad_item.digital_pressed = new_rec.pressed_digital;
            pad_item.analog_now = new_rec.analog;
            pad_item.analog_pressed = new_rec.pressed_analog;
            pad_item.stick_lx = r_in.left_x;
            pad_item.stick_ly = r_in.left_y;
            pad_item.stick_rx = r_in.right_x;
            pad_item.stick_ry = r_in.right_y;
        end
    end

    // combined pad from the records, already updated by the pad pass
    grc_combine #(
        .NUM_PADS (NUM_PADS)
    ) u_combine (
        .i_recs     (r_rec),
        .o_combined (comb_item)
    );

    assign n_out = r_phase ? comb_item : pad_item;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ANALOG_THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_phase <= !r_phase && r_in.frame_end;
            end
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // pad records: an absent pad clears its whole history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PADS; p++) begin
                r_rec[p] <= '0;
            end
        end else if (pad_fire) begin
            for (int p = 0; p < NUM_PADS; p++) begin
                if (int'(r_in.pad_index) == p) begin
                    r_rec[p] <= r_in.present ? new_rec : '0;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // combined pass only ever follows the pad pass of a frame_end report
    a_phase_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_in_valid && r_in.frame_end))
        else $error("combined pass pending without a held frame_end report");

    // the combined pass delivers the combined pad as the last result
    a_comb_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_phase) |=> (o_out_valid && o_out_item.source == COMBINED_SOURCE
                               && o_out_item.run_last && o_out_item.connected))
        else $error("combined pass did not produce the combined pad");

    // a pad pass of a frame_end report is never the last result
    a_pad_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_phase && r_in.frame_end) |=> (o_out_valid && !o_out_item.run_last))
        else $error("pad result of a frame end report flagged as last");

    // a disconnected result carries no buttons or levels
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.connected) |->
            (o_out_item.digital_now == '0 && o_out_item.analog_now == '0
             && o_out_item.digital_pressed == '0 && o_out_item.analog_pressed == '0))
        else $error("disconnected result carries button state");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for gamepad_report_conditioner_unit
// depends on grc_pkg and the unit's rtl; keeps its own model of the pad records to
// work out every result and checks the results in order as they are transferred

module tb;
    import grc_pkg::*;

    // longest run of cycles with no transfer on either channel before the run is abandoned
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int MAX_REPORTED = 10;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic [7:0] cfg_wdata = '0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b1;
    t_out_item out_item;

    // model of the block: threshold and one record per pad
    logic [7:0] threshold_model;
    t_pad_rec   pad_record [GRC_NUM_PADS];

    // conditioned results still to come, oldest first
    t_out_item pending_results [$];

    int  fail_count = 0;
    int  quiet_cycles = 0;
    int  out_stall_left = 0;
    bit  idle_on = 1'b1;

    gamepad_report_conditioner_unit #(
        .NUM_PADS (GRC_NUM_PADS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // model of the conditioning
    // ------------------------------------------------------------------

    // buttons[3:0] is the d-pad, buttons[15:4] the other buttons
    function automatic t_in_item make_report(logic [1:0] pad, logic present,
                                             logic [15:0] buttons, logic [63:0] levels,
                                             logic [15:0] lx, logic [15:0] ly,
                                             logic [15:0] rx, logic [15:0] ry,
                                             logic fend);
        t_in_item r;
        r.pad_index = pad;
        r.present = present;
        r.dpad_bits = buttons[3:0];
        r.other_buttons = buttons[15:4];
        r.analog_levels = levels;
        r.left_x = lx;
        r.left_y = ly;
        r.right_x = rx;
        r.right_y = ry;
        r.frame_end = fend;
        return r;
    endfunction

    // update the pad records for one report and queue the result(s) it causes
    task automatic condition_report(input t_in_item r);
        t_out_item  pad_res;
        t_out_item  mix;
        logic [15:0] dig;
        logic [63:0] lit;
        logic [7:0]  hold;
        logic [7:0]  level;
        int p;
        p = int'(r.pad_index);
        pad_res = '0;
        pad_res.source = {1'b0, r.pad_index};
        pad_res.run_last = !r.frame_end;
        if (p < GRC_NUM_PADS) begin
            if (!r.present) begin
                // absent pad forgets everything, press history too
                pad_record[p] = '0;
            end else begin
                dig = {r.other_buttons, r.dpad_bits};
                lit = '0;
                hold = '0;
                for (int b = 0; b < NUM_LEVELS; b++) begin
                    level = r.analog_levels[b*LEVEL_W +: LEVEL_W];
                    if (level > threshold_model) begin
                        lit[b*LEVEL_W +: LEVEL_W] = level;
                        hold[b] = 1'b1;
                    end
                end
                // rising edges against what the pad held at its last report
                pad_record[p].pressed_digital = dig & ~pad_record[p].held_digital;
                pad_record[p].held_digital = dig;
                pad_record[p].pressed_analog = hold & ~pad_record[p].held_analog;
                pad_record[p].held_analog = hold;
                pad_record[p].analog = lit;
                pad_record[p].lx = r.left_x;
                pad_record[p].ly = r.left_y;
                pad_record[p].rx = r.right_x;
                pad_record[p].ry = r.right_y;
                pad_res.connected = 1'b1;
                pad_res.digital_now = dig;
                pad_res.digital_pressed = pad_record[p].pressed_digital;
                pad_res.analog_now = lit;
                pad_res.analog_pressed = pad_record[p].pressed_analog;
                pad_res.stick_lx = r.left_x;
                pad_res.stick_ly = r.left_y;
                pad_res.stick_rx = r.right_x;
                pad_res.stick_ry = r.right_y;
            end
        end
        pending_results.push_back(pad_res);

        if (r.frame_end) begin
            // combined pad: OR of buttons and flags, max of levels, wrapped stick sums
            mix = '0;
            mix.source = COMBINED_SOURCE;
            mix.connected = 1'b1;
            mix.run_last = 1'b1;
            for (int q = 0; q < GRC_NUM_PADS; q++) begin
                mix.digital_now |= pad_record[q].held_digital;
                mix.digital_pressed |= pad_record[q].pressed_digital;
                mix.analog_pressed |= pad_record[q].pressed_analog;
                mix.stick_lx = mix.stick_lx + pad_record[q].lx;
                mix.stick_ly = mix.stick_ly + pad_record[q].ly;
                mix.stick_rx = mix.stick_rx + pad_record[q].rx;
                mix.stick_ry = mix.stick_ry + pad_record[q].ry;
                for (int b = 0; b < NUM_LEVELS; b++) begin
                    level = pad_record[q].analog[b*LEVEL_W +: LEVEL_W];
                    if (level > mix.analog_now[b*LEVEL_W +: LEVEL_W])
                        mix.analog_now[b*LEVEL_W +: LEVEL_W] = level;
                end
            end
            pending_results.push_back(mix);
        end
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // one report transfer, with an occasional idle burst in front of it;
    // valid is left high so a following report can go straight after
    task automatic send_report(input t_in_item r);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= r;
        do @(posedge clk); while (!in_ready);
        condition_report(r);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results;
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // threshold writes only ever happen with the block empty
    task automatic write_threshold(input logic [7:0] value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        threshold_model = value;
    endtask

    function automatic logic [15:0] random_stick();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly small changes to what a pad already holds, so press edges and holds both
    // come up often; levels cluster around the threshold
    function automatic t_in_item random_report();
        logic [1:0]  pad;
        logic [15:0] dig;
        logic [63:0] levels;
        logic [7:0]  level;
        pad = 2'($urandom_range(0, GRC_NUM_PADS - 1));
        case ($urandom_range(0, 3))
            0: dig = 16'($urandom);
            1, 2: dig = pad_record[pad].held_digital ^ (16'h1 << $urandom_range(0, 15));
            default: dig = pad_record[pad].held_digital;
        endcase
        for (int b = 0; b < NUM_LEVELS; b++) begin
            case ($urandom_range(0, 5))
                0: level = 8'h00;
                1: level = threshold_model;
                2: level = threshold_model + 8'd1;
                3: level = 8'hFF;
                4: level = pad_record[pad].analog[b*LEVEL_W +: LEVEL_W];
                default: level = 8'($urandom);
            endcase
            levels[b*LEVEL_W +: LEVEL_W] = level;
        end
        return make_report(pad, $urandom_range(0, 9) != 0, dig, levels,
                           random_stick(), random_stick(), random_stick(), random_stick(),
                           $urandom_range(0, 2) == 0);
    endfunction

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------

    // receiver stalls in bursts while idling is on
    always @(posedge clk) begin
        if (out_stall_left != 0) begin
            out_stall_left <= out_stall_left - 1;
            out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            out_stall_left <= $urandom_range(0, 18);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic string format_result(t_out_item r);
        return $sformatf("src=%0d con=%0b dn=%h dp=%h an=%h ap=%h sticks=%h %h %h %h last=%0b",
                         r.source, r.connected, r.digital_now, r.digital_pressed,
                         r.analog_now, r.analog_pressed, r.stick_lx, r.stick_ly,
                         r.stick_rx, r.stick_ry, r.run_last);
    endfunction

    // every result transfer is matched against the oldest expected result
    always @(posedge clk) begin : check_result
        t_out_item want;
        bit bad;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTED)
                    $display("unexpected result: %s", format_result(out_item));
            end else begin
                want = pending_results.pop_front();
                bad = (out_item.source !== want.source)
                   || (out_item.connected !== want.connected)
                   || (out_item.digital_now !== want.digital_now)
                   || (out_item.digital_pressed !== want.digital_pressed)
                   || (out_item.analog_now !== want.analog_now)
                   || (out_item.analog_pressed !== want.analog_pressed)
                   || (out_item.stick_lx !== want.stick_lx)
                   || (out_item.stick_ly !== want.stick_ly)
                   || (out_item.stick_rx !== want.stick_rx)
                   || (out_item.stick_ry !== want.stick_ry)
                   || (out_item.run_last !== want.run_last);
                if (bad) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTED) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", format_result(want));
                        $display("  actual   %s", format_result(out_item));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: any transfer on either channel counts as progress
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_CYCLES) @(posedge clk);
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_CYCLES);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extremes of every field at the reset threshold, absent pads, press edges,
    // stale press flags in the combined pad and stick sums that wrap
    task automatic test_directed_reports;
        // everything pressed and sticks at full positive
        send_report(make_report(2'd0, 1'b1, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
        // same again: held, nothing new pressed
        send_report(make_report(2'd0, 1'b1, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
        // levels at and just above the threshold, full negative sticks
        send_report(make_report(2'd1, 1'b1, 16'h0000, 64'h3130_3130_3130_3130,
                                16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
        // a stick sum wraps past the negative limit
        send_report(make_report(2'd2, 1'b1, 16'h0001, 64'h0000_0000_0000_0031,
                                16'h7FFF, 16'h7FFF, 16'h8000, 16'h0001, 1'b1));
        send_report(make_report(2'd3, 1'b1, 16'hA5A5, 64'h00FF_0130_31FE_8040,
                                16'hFFFF, 16'h0000, 16'h1234, 16'hEDCB, 1'b1));
        // absent pad clears its record, combined loses it
        send_report(make_report(2'd0, 1'b0, 16'h0000, 64'h0,
                                16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
        // after a clear everything held counts as newly pressed
        send_report(make_report(2'd0, 1'b1, 16'h00F5, 64'h4000_0000_0000_0050,
                                16'h0010, 16'hFFF0, 16'h0100, 16'hFF00, 1'b0));
        // partial release and new presses
        send_report(make_report(2'd0, 1'b1, 16'h0F0A, 64'h4000_0000_0000_0000,
                                16'h0010, 16'hFFF0, 16'h0100, 16'hFF00, 1'b1));
        // absent with all-ones content still reads as zeros
        send_report(make_report(2'd1, 1'b0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        send_report(make_report(2'd1, 1'b0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_report(make_report(2'd2, 1'b1, 16'h00FF, 64'hFF00_FF00_FF00_FF00,
                                16'h0001, 16'h0002, 16'h0003, 16'h0004, 1'b0));
        // pad 2 press flags stay in the combined pad from its last report
        send_report(make_report(2'd3, 1'b1, 16'hA5A5, 64'h00FF_0130_31FE_8040,
                                16'hFFFF, 16'h0000, 16'h1234, 16'hEDCB, 1'b1));
        send_report(make_report(2'd3, 1'b1, 16'h5A5A, 64'h0,
                                16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
        send_report(make_report(2'd0, 1'b1, 16'h0000, 64'h0,
                                16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    endtask

    // threshold 0 lets any non-zero level through, 255 lets nothing through
    task automatic test_threshold_extremes;
        write_threshold(8'd0);
        send_report(make_report(2'd0, 1'b1, 16'h1234, 64'h0100_0000_FF00_0001,
                                16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b1));
        send_report(make_report(2'd1, 1'b1, 16'h4321, 64'h0000_0102_0304_0506,
                                16'h0002, 16'h0002, 16'h0002, 16'h0002, 1'b1));
        write_threshold(8'd255);
        send_report(make_report(2'd0, 1'b1, 16'h1234, 64'hFFFF_FFFF_FFFF_FFFF,
                                16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b1));
        send_report(make_report(2'd2, 1'b1, 16'h0000, 64'hFEFF_00FF_80FF_FF01,
                                16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
        write_threshold(8'd254);
        send_report(make_report(2'd3, 1'b1, 16'hFFFF, 64'hFFFE_FFFE_FFFE_FFFE,
                                16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
        send_report(make_report(2'd0, 1'b1, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF,
                                16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    endtask

    // random traffic in phases, one threshold per phase, extremes included
    task automatic test_random_traffic;
        logic [7:0] thr;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: thr = 8'($urandom_range(1, 254));
                1: thr = 8'd0;
                2: thr = ANALOG_THRESHOLD_RESET;
                3: thr = 8'd255;
                default: thr = 8'($urandom);
            endcase
            write_threshold(thr);
            for (int i = 0; i < 110; i++) begin
                // once mid-run the sender holds off until the pipeline is empty
                if (phase == 2 && i == 55)
                    drain_results();
                send_report(random_report());
            end
        end
    endtask

    // closing stretch with no idling on either side
    task automatic test_back_to_back;
        write_threshold(8'($urandom));
        idle_on = 1'b0;
        for (int i = 0; i < 100; i++)
            send_report(random_report());
    endtask

    initial begin
        threshold_model = ANALOG_THRESHOLD_RESET;
        for (int p = 0; p < GRC_NUM_PADS; p++)
            pad_record[p] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_reports();
        test_threshold_extremes();
        test_random_traffic();
        test_back_to_back();

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
rtl/grc_pkg.sv
rtl/grc_combine.sv
rtl/gamepad_report_conditioner_unit.sv
tb/tb.sv
